[hdl/xor_checked_frame_deframer_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the deframer
// Clocked on clk, quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef XOR_CHECKED_FRAME_DEFRAMER_ASSERT_SVH
`define XOR_CHECKED_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication.
`define XCFD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define XCFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/xcfd_pkg.sv]
// ----------------------------------------------------------------------------
// xcfd_pkg
// Constants and types shared by the deframer modules.
// ----------------------------------------------------------------------------
package xcfd_pkg;

	localparam int FRAME_BYTES = 37;
	localparam int CNT_W       = $clog2(FRAME_BYTES + 1);

	localparam logic [7:0]  HEADER_BYTE = 8'hFF;
	localparam logic [15:0] CMD_RESET   = 16'h2001;

	// Byte positions inside a frame
	localparam int HDR_BYTES   = 4;
	localparam int CMD_POS     = 8;
	localparam int ANCHOR_POS  = 12;
	localparam int TAG_POS     = 16;
	localparam int DIST_POS    = 20;
	localparam int AZIM_POS    = 24;
	localparam int ELEV_POS    = 26;

	localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(FRAME_BYTES);
	localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(FRAME_BYTES - 1);
	localparam logic [CNT_W-1:0] CNT_HUNT  = CNT_W'(HDR_BYTES);
	localparam logic [CNT_W-1:0] CNT_KEEP  = CNT_W'(HDR_BYTES - 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [31:0]        anchor;
		logic [31:0]        tag_id;
		logic [31:0]        distance;
		logic signed [15:0] azimuth;
		logic signed [15:0] elevation;
	} frame_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

[hdl/xcfd_front.sv]
// ----------------------------------------------------------------------------
// xcfd_front
// Byte window, header hunt and frame check; flags a good frame on accept.
// ----------------------------------------------------------------------------
module xcfd_front
	import xcfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_acc,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	output logic        frame_valid,
	output frame_rec_t  frame_rec
);

	// Shift line: newest byte at the top index, held bytes are the top cnt_q.
	logic [7:0] win_q [FRAME_BYTES];
	// XOR of all bytes received before each held byte
	logic [7:0] pre_q [FRAME_BYTES];
	logic [7:0] acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic [15:0] cmd_q;

	logic [CNT_W-1:0] cnt_base;
	logic [CNT_W-1:0] cnt_inc;
	logic [CNT_W-1:0] cnt_next;
	logic hdr_hunt_ok;
	logic hdr_full_ok;
	logic sum_ok;
	logic cmd_ok;
	logic frame_ok;

	assign cnt_base = (cnt_q >= CNT_FULL) ? CNT_LAST : cnt_q;
	assign cnt_inc  = cnt_base + CNT_W'(1);

	// Taps are read one place above their frame position: the line shifts on accept.
	assign hdr_hunt_ok = (win_q[FRAME_BYTES-3] == HEADER_BYTE) &&
	                     (win_q[FRAME_BYTES-2] == HEADER_BYTE) &&
	                     (win_q[FRAME_BYTES-1] == HEADER_BYTE) &&
	                     (rx_byte == HEADER_BYTE);

	assign hdr_full_ok = (win_q[1] == HEADER_BYTE) && (win_q[2] == HEADER_BYTE) &&
	                     (win_q[3] == HEADER_BYTE) && (win_q[4] == HEADER_BYTE);

	// XOR over the frame body is the difference of two running prefixes.
	assign sum_ok   = ((pre_q[1] ^ acc_q) == rx_byte);
	assign cmd_ok   = ({win_q[CMD_POS+1], win_q[CMD_POS+2]} == cmd_q);
	assign frame_ok = hdr_full_ok && sum_ok && cmd_ok;

	always_comb begin
		cnt_next    = cnt_inc;
		frame_valid = 1'b0;
		if (cnt_inc == CNT_HUNT && !hdr_hunt_ok) begin
			cnt_next = CNT_KEEP;
		end else if (cnt_inc == CNT_FULL) begin
			if (frame_ok) begin
				cnt_next    = '0;
				frame_valid = in_acc;
			end else begin
				cnt_next = CNT_LAST;
			end
		end
	end

	always_comb begin
		frame_rec.anchor    = {win_q[ANCHOR_POS+4], win_q[ANCHOR_POS+3],
		                       win_q[ANCHOR_POS+2], win_q[ANCHOR_POS+1]};
		frame_rec.tag_id    = {win_q[TAG_POS+4], win_q[TAG_POS+3],
		                       win_q[TAG_POS+2], win_q[TAG_POS+1]};
		frame_rec.distance  = {win_q[DIST_POS+4], win_q[DIST_POS+3],
		                       win_q[DIST_POS+2], win_q[DIST_POS+1]};
		frame_rec.azimuth   = {win_q[AZIM_POS+2], win_q[AZIM_POS+1]};
		frame_rec.elevation = {win_q[ELEV_POS+2], win_q[ELEV_POS+1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			acc_q <= '0;
			cmd_q <= CMD_RESET;
		end else begin
			if (in_acc) begin
				cnt_q <= cnt_next;
				acc_q <= acc_q ^ rx_byte;
			end
			if (cfg_we) begin
				cmd_q <= cfg_wdata;
			end
		end
	end

	// Advance the byte and prefix lines.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int i = 0; i < FRAME_BYTES - 1; i++) begin
				win_q[i] <= win_q[i+1];
				pre_q[i] <= pre_q[i+1];
			end
			win_q[FRAME_BYTES-1] <= rx_byte;
			pre_q[FRAME_BYTES-1] <= acc_q;
		end
	end

endmodule

[hdl/xcfd_queue.sv]
// ----------------------------------------------------------------------------
// xcfd_queue
// Short result queue between the frame checker and the output stage.
// ----------------------------------------------------------------------------
module xcfd_queue
	import xcfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  frame_rec_t  push_rec,
	input  logic        pop,
	output frame_rec_t  pop_rec,
	output queue_stat_t stat
);

	frame_rec_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	assign stat.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign pop_rec    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

endmodule

[hdl/xcfd_back.sv]
// ----------------------------------------------------------------------------
// xcfd_back
// Output register: presents the oldest result and drains the queue.
// ----------------------------------------------------------------------------
module xcfd_back
	import xcfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  frame_rec_t q_rec,
	output logic       q_pop,
	input  logic       pop,
	output logic       empty,
	output frame_rec_t out_rec
);

	logic       valid_q;
	frame_rec_t rec_q;

	// Load when the register is free or being drained this cycle.
	assign q_pop   = !q_empty && (!valid_q || pop);
	assign empty   = !valid_q;
	assign out_rec = rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rec_q <= q_rec;
		end
	end

endmodule

[hdl/xor_checked_frame_deframer.sv]
// ----------------------------------------------------------------------------
// xor_checked_frame_deframer
// Fixed-length frame deframer with header hunt and XOR checksum.
// ----------------------------------------------------------------------------
// Takes one received byte per clock whenever full is low and emits one
// result for each good frame: four 0xFF header bytes, an XOR over the body
// that matches the last byte, and a big-endian command equal to the value
// last written on cfg_wdata (0x2001 after reset). Each byte is checked in
// the cycle it is transferred, so the sustained rate is one byte per cycle
// while full is low; a good frame is written into the queue when its last
// byte is transferred, then moves on into the output register and waits
// there until popped. Between checker and output register sits a two-entry
// queue; full goes high only when that queue holds two results the
// consumer has not drained, so a stalled consumer blocks input after at
// most three pending results. No clearing pass runs after reset: the byte
// window is never read before it has been filled.
// ----------------------------------------------------------------------------
module xor_checked_frame_deframer
	import xcfd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// byte input
	input  logic               push,
	output logic               full,
	input  logic [7:0]         rx_byte,
	// command register write
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	// result output
	output logic               empty,
	input  logic               pop,
	output logic [31:0]        anchor,
	output logic [31:0]        tag_id,
	output logic [31:0]        distance,
	output logic signed [15:0] azimuth,
	output logic signed [15:0] elevation
);

`include "xor_checked_frame_deframer_assert.svh"

	logic        in_acc;
	logic        frame_valid;
	frame_rec_t  frame_rec;
	frame_rec_t  q_rec;
	frame_rec_t  out_rec;
	queue_stat_t q_stat;
	logic        q_pop;
	logic        drain_last;

	// Transfer a byte only while the queue can take a result.
	assign full   = q_stat.full;
	assign in_acc = push && !full;

	// Front: hold the window, hunt for the header, check full frames.
	xcfd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_acc      (in_acc),
		.rx_byte     (rx_byte),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.frame_valid (frame_valid),
		.frame_rec   (frame_rec)
	);

	// Decouple checker and consumer.
	xcfd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (frame_valid),
		.push_rec (frame_rec),
		.pop      (q_pop),
		.pop_rec  (q_rec),
		.stat     (q_stat)
	);

	// Back: present the oldest result until it is popped.
	xcfd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_stat.empty),
		.q_rec   (q_rec),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.out_rec (out_rec)
	);

	assign anchor    = out_rec.anchor;
	assign tag_id    = out_rec.tag_id;
	assign distance  = out_rec.distance;
	assign azimuth   = out_rec.azimuth;
	assign elevation = out_rec.elevation;

	// Last result leaves the output with nothing behind it.
	assign drain_last = pop && !empty && q_stat.empty && !frame_valid;

	// A result is only raised by a transferred byte, never into a full queue.
	`XCFD_ASSERT_NOW(a_frame_on_accept, frame_valid, in_acc && !q_stat.full, "no transfer")
	// A free output register picks up a waiting result in the next cycle.
	`XCFD_ASSERT_NEXT(a_back_fills, empty && !q_stat.empty, !empty, "not refilled")
	// Draining the last result leaves the output empty.
	`XCFD_ASSERT_NEXT(a_back_drains, drain_last, empty, "stale result after pop")

endmodule
